// File: sv/last_note_priority_voice_defines.svh
// Assertion macros for the last-note-priority voice manager.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef LAST_NOTE_PRIORITY_VOICE_DEFINES_SVH
`define LAST_NOTE_PRIORITY_VOICE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LNPV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LNPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lnpv_pkg.sv
// Shared types and constants for the last-note-priority voice manager.
// No dependencies.
`default_nettype none

package lnpv_pkg;

  localparam int NOTE_W          = 7;
  localparam int CHAN_W          = 5;
  localparam int VEL_W           = 7;
  localparam int NOTE_COUNT      = 128;
  localparam int TOTAL_W         = $clog2(NOTE_COUNT + 1);
  localparam int STACK_DEPTH_DEF = 128;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } in_beat_t;

  typedef struct packed {
    logic              gate;
    logic [CHAN_W-1:0] voice_channel;
    logic [NOTE_W-1:0] voice_note;
    logic [VEL_W-1:0]  voice_velocity;
    logic              push_dropped;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } lnpv_state_t;

endpackage

`default_nettype wire

// File: sv/lnpv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lnpv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/last_note_priority_voice.sv
// Last-note-priority monophonic voice manager. A note-on waits in the item
// register until the output register is free; its result is then registered
// and in_ready returns in the same cycle. A release of the current note scans
// the note stack from its top, one RAM read per cycle while the output is free
// (registered read, pipelined against the held-bit check). Other releases give
// no result. One event is in work at a time; in_ready is high only between
// events. A result sits in an output register, so the next event can be
// accepted while it waits; a note-on or a scan then holds in place until that
// result is taken.
// Depends on lnpv_pkg, lnpv_ram and last_note_priority_voice_defines.svh.
`default_nettype none

`include "last_note_priority_voice_defines.svh"

module last_note_priority_voice
  import lnpv_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_beat
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int TOP_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (TOP_W > TOTAL_W) ? TOP_W : TOTAL_W;

  lnpv_state_t state_r, state_nxt;

  in_beat_t               item_r, item_nxt;
  logic [NOTE_COUNT-1:0]  held_map_r, held_map_nxt;
  logic [TOP_W-1:0]       stack_top_r, stack_top_nxt;
  logic [TOTAL_W-1:0]     held_total_r, held_total_nxt;
  logic [NOTE_W-1:0]      current_note_r, current_note_nxt;
  logic                   current_valid_r, current_valid_nxt;
  logic [VEL_W-1:0]       last_velocity_r, last_velocity_nxt;
  logic [TOP_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [TOP_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  out_beat_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   ram_we;
  logic                   ram_re;
  logic [TOP_W-1:0]       scan_dec;
  logic [NOTE_W-1:0]      ram_rd_data;

  logic                   out_free;
  logic                   is_press;
  logic                   note_held;
  logic                   is_current;
  logic [TOTAL_W-1:0]     total_dec;
  logic [TOTAL_W-1:0]     total_rel;

  assign scan_dec = scan_idx_r - TOP_W'(1);

  lnpv_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (stack_top_r[AW-1:0]),
    .wr_data (item_r.note),
    .rd_en   (ram_re),
    .rd_addr (scan_dec[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign is_press   = (item_r.op == OP_NOTE_ON) && (item_r.velocity != '0);
  assign note_held  = held_map_r[item_r.note];
  assign is_current = current_valid_r && (current_note_r == item_r.note);
  assign total_dec  = (held_total_r == '0) ? '0 : held_total_r - TOTAL_W'(1);
  assign total_rel  = note_held ? total_dec : held_total_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    item_nxt          = item_r;
    held_map_nxt      = held_map_r;
    stack_top_nxt     = stack_top_r;
    held_total_nxt    = held_total_r;
    current_note_nxt  = current_note_r;
    current_valid_nxt = current_valid_r;
    last_velocity_nxt = last_velocity_r;
    scan_idx_nxt      = scan_idx_r;
    chk_idx_nxt       = chk_idx_r;
    chk_vld_nxt       = chk_vld_r;
    out_nxt           = out_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    ram_we            = 1'b0;
    ram_re            = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_beat;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (is_press) begin
          if (out_free) begin
            out_nxt.push_dropped = 1'b0;
            if (!note_held) begin
              if (stack_top_r < TOP_W'(STACK_DEPTH)) begin
                ram_we                     = 1'b1;
                stack_top_nxt              = stack_top_r + TOP_W'(1);
                held_map_nxt[item_r.note]  = 1'b1;
                held_total_nxt             = held_total_r + TOTAL_W'(1);
              end else begin
                out_nxt.push_dropped = 1'b1;
              end
            end
            current_note_nxt       = item_r.note;
            current_valid_nxt      = 1'b1;
            last_velocity_nxt      = item_r.velocity;
            out_nxt.gate           = 1'b1;
            out_nxt.voice_channel  = item_r.channel;
            out_nxt.voice_note     = item_r.note;
            out_nxt.voice_velocity = item_r.velocity;
            out_valid_nxt          = 1'b1;
            state_nxt              = ST_IDLE;
          end
        end else begin
          held_map_nxt[item_r.note] = 1'b0;
          held_total_nxt            = total_rel;
          if (is_current) begin
            // no held notes left: scan nothing, go straight to voice off
            scan_idx_nxt = (total_rel != '0) ? stack_top_r : '0;
            chk_vld_nxt  = 1'b0;
            state_nxt    = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        if (out_free) begin
          if (chk_vld_r && held_map_r[ram_rd_data]) begin
            current_note_nxt       = ram_rd_data;
            stack_top_nxt          = chk_idx_r;
            out_nxt.gate           = 1'b1;
            out_nxt.voice_channel  = item_r.channel;
            out_nxt.voice_note     = ram_rd_data;
            out_nxt.voice_velocity = last_velocity_r;
            out_nxt.push_dropped   = 1'b0;
            out_valid_nxt          = 1'b1;
            chk_vld_nxt            = 1'b0;
            state_nxt              = ST_IDLE;
          end else if (scan_idx_r != '0) begin
            ram_re       = 1'b1;
            scan_idx_nxt = scan_dec;
            chk_idx_nxt  = scan_idx_r;
            chk_vld_nxt  = 1'b1;
          end else begin
            held_total_nxt         = '0;
            stack_top_nxt          = '0;
            current_valid_nxt      = 1'b0;
            last_velocity_nxt      = '0;
            out_nxt.gate           = 1'b0;
            out_nxt.voice_channel  = item_r.channel;
            out_nxt.voice_note     = item_r.note;
            out_nxt.voice_velocity = '0;
            out_nxt.push_dropped   = 1'b0;
            out_valid_nxt          = 1'b1;
            chk_vld_nxt            = 1'b0;
            state_nxt              = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_map_r      <= '0;
      stack_top_r     <= '0;
      held_total_r    <= '0;
      current_note_r  <= '0;
      current_valid_r <= 1'b0;
      last_velocity_r <= '0;
      chk_vld_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      held_map_r      <= held_map_nxt;
      stack_top_r     <= stack_top_nxt;
      held_total_r    <= held_total_nxt;
      current_note_r  <= current_note_nxt;
      current_valid_r <= current_valid_nxt;
      last_velocity_r <= last_velocity_nxt;
      chk_vld_r       <= chk_vld_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_r      <= out_nxt;
  end

  // every held note has an entry below the stack top
  `LNPV_ASSERT_NOW(a_held_below_top, 1'b1,
    CMP_W'(held_total_r) <= CMP_W'(stack_top_r), "held count exceeds stack top")
  `LNPV_ASSERT_NOW(a_top_range, 1'b1,
    stack_top_r <= TOP_W'(STACK_DEPTH), "stack top beyond depth")
  `LNPV_ASSERT_NOW(a_idle_velocity, !current_valid_r,
    last_velocity_r == '0, "velocity kept with no current note")
  `LNPV_ASSERT_NEXT(a_scan_ends, (state_r == ST_SCAN) && out_free && !chk_vld_r &&
    (scan_idx_r == '0), (state_r == ST_IDLE) && out_valid_r, "scan end gave no result")

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for last_note_priority_voice: directed table, stack-fill bursts and random
// note traffic, checked beat by beat against typed rows or a last-note-priority predictor.
// Depends on lnpv_pkg and the last_note_priority_voice RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lnpv_pkg::*;

  localparam int DEPTH      = STACK_DEPTH_DEF;
  localparam int RAND_ITEMS = 760;

  typedef struct {
    in_beat_t  ev;
    bit        typed;
    bit        want;
    out_beat_t res;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  // predictor state
  bit             held_bits [NOTE_COUNT];
  bit [NOTE_W-1:0] pushed_notes [DEPTH];
  int             stack_fill;
  int             held_count;
  bit [NOTE_W-1:0] cur_note;
  bit             cur_on;
  bit [VEL_W-1:0] last_vel;

  out_beat_t      pending_voice [$];
  dir_row_t       dir_tab [$];
  int             err_count    = 0;
  int             results_seen = 0;
  bit             quiet        = 1'b0;
  bit             squeezed     = 1'b0;
  bit [NOTE_W-1:0] pool [10];

  last_note_priority_voice #(.STACK_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always #1 clk = ~clk;

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic in_beat_t mk_in(logic op, int ch, int note, int vel);
    in_beat_t b;
    b.op       = op;
    b.channel  = ch[CHAN_W-1:0];
    b.note     = note[NOTE_W-1:0];
    b.velocity = vel[VEL_W-1:0];
    return b;
  endfunction

  function automatic out_beat_t mk_out(int gate, int ch, int note, int vel, int drop);
    out_beat_t b;
    b.gate           = gate[0];
    b.voice_channel  = ch[CHAN_W-1:0];
    b.voice_note     = note[NOTE_W-1:0];
    b.voice_velocity = vel[VEL_W-1:0];
    b.push_dropped   = drop[0];
    return b;
  endfunction

  function automatic dir_row_t mk_row(in_beat_t ev, bit typed, bit want, out_beat_t res);
    dir_row_t r;
    r.ev    = ev;
    r.typed = typed;
    r.want  = want;
    r.res   = res;
    return r;
  endfunction

  function automatic void voice_clear_all();
    for (int n = 0; n < NOTE_COUNT; n++) held_bits[n] = 1'b0;
    stack_fill = 0;
    held_count = 0;
    cur_note   = '0;
    cur_on     = 1'b0;
    last_vel   = '0;
  endfunction

  function automatic void drop_held(bit [NOTE_W-1:0] n);
    if (held_bits[n]) begin
      held_bits[n] = 1'b0;
      if (held_count > 0) held_count--;
    end
  endfunction

  function automatic void voice_next(input in_beat_t ev, output bit has_res,
                                     output out_beat_t res);
    int i;
    bit [NOTE_W-1:0] cand;
    has_res = 1'b0;
    res     = '0;
    if (ev.op == OP_NOTE_ON && ev.velocity != '0) begin
      if (!held_bits[ev.note]) begin
        if (stack_fill < DEPTH) begin
          pushed_notes[stack_fill] = ev.note;
          stack_fill++;
          held_bits[ev.note] = 1'b1;
          held_count++;
        end else begin
          res.push_dropped = 1'b1;
        end
      end
      cur_note = ev.note;
      cur_on   = 1'b1;
      last_vel = ev.velocity;
      has_res  = 1'b1;
      res.gate           = 1'b1;
      res.voice_channel  = ev.channel;
      res.voice_note     = ev.note;
      res.voice_velocity = ev.velocity;
      return;
    end
    if (!cur_on || cur_note != ev.note) begin
      drop_held(ev.note);
      return;
    end
    drop_held(ev.note);
    has_res = 1'b1;
    res.voice_channel = ev.channel;
    if (held_count > 0) begin
      i = stack_fill;
      while (i > 0) begin
        cand = pushed_notes[i-1];
        if (held_bits[cand]) begin
          cur_note   = cand;
          stack_fill = i;
          res.gate           = 1'b1;
          res.voice_note     = cand;
          res.voice_velocity = last_vel;
          return;
        end
        i--;
      end
    end
    held_count = 0;
    stack_fill = 0;
    cur_on     = 1'b0;
    last_vel   = '0;
    res.gate           = 1'b0;
    res.voice_note     = ev.note;
    res.voice_velocity = '0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_voice(out_beat_t got);
    out_beat_t exp_b;
    if (pending_voice.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat %p", got));
      return;
    end
    exp_b = pending_voice.pop_front();
    if (got.gate !== exp_b.gate)
      flag_mismatch($sformatf("gate %0d, want %0d", got.gate, exp_b.gate));
    if (got.voice_channel !== exp_b.voice_channel)
      flag_mismatch($sformatf("channel %0d, want %0d", got.voice_channel,
                              exp_b.voice_channel));
    if (got.voice_note !== exp_b.voice_note)
      flag_mismatch($sformatf("note %0d, want %0d", got.voice_note, exp_b.voice_note));
    if (got.voice_velocity !== exp_b.voice_velocity)
      flag_mismatch($sformatf("velocity %0d, want %0d", got.voice_velocity,
                              exp_b.voice_velocity));
    if (got.push_dropped !== exp_b.push_dropped)
      flag_mismatch($sformatf("push_dropped %0d, want %0d", got.push_dropped,
                              exp_b.push_dropped));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      check_voice(out_beat);
    end
  end

  // result side: random stalls, plus one long hold-off while events keep coming
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!squeezed && results_seen >= 400) begin
        squeezed   = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic offer(in_beat_t ev, bit typed, bit want, out_beat_t want_res);
    int gap;
    bit has;
    out_beat_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= ev;
    do @(posedge clk); while (!in_ready);
    voice_next(ev, has, res);
    if (typed) begin
      has = want;
      res = want_res;
    end
    if (has) pending_voice.push_back(res);
  endtask

  function automatic int rand_chan();
    return $urandom_range(0, 31);
  endfunction

  // press every note, overflow the stack, then release everything in random order
  task automatic fill_stack();
    bit [NOTE_W-1:0] order [NOTE_COUNT];
    bit [NOTE_W-1:0] tmp;
    int j;
    int victim;
    for (int n = 0; n < NOTE_COUNT; n++) order[n] = n[NOTE_W-1:0];
    for (int n = NOTE_COUNT - 1; n > 0; n--) begin
      j = $urandom_range(0, n);
      tmp = order[n]; order[n] = order[j]; order[j] = tmp;
    end
    for (int n = 0; n < NOTE_COUNT; n++)
      offer(mk_in(OP_NOTE_ON, rand_chan(), order[n], $urandom_range(1, 127)), 0, 0, '0);
    for (int k = 0; k < 3; k++) begin
      victim = order[$urandom_range(0, NOTE_COUNT - 2)];
      offer(mk_in(OP_NOTE_OFF, rand_chan(), victim, $urandom_range(0, 127)), 0, 0, '0);
      offer(mk_in(OP_NOTE_ON, rand_chan(), victim, $urandom_range(1, 127)), 0, 0, '0);
    end
    offer(mk_in(OP_NOTE_OFF, rand_chan(), cur_note, $urandom_range(0, 127)), 0, 0, '0);
    for (int n = NOTE_COUNT - 1; n > 0; n--) begin
      j = $urandom_range(0, n);
      tmp = order[n]; order[n] = order[j]; order[j] = tmp;
    end
    for (int n = 0; n < NOTE_COUNT; n++) begin
      if ($urandom_range(0, 3) == 0)
        offer(mk_in(OP_NOTE_ON, rand_chan(), order[n], 0), 0, 0, '0);
      else
        offer(mk_in(OP_NOTE_OFF, rand_chan(), order[n], $urandom_range(0, 127)), 0, 0, '0);
    end
  endtask

  function automatic int pick_note();
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, 9)];
    return $urandom_range(0, 127);
  endfunction

  function automatic in_beat_t rand_event();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 10)
      return mk_in(1'($urandom_range(0, 1)), rand_chan(), $urandom_range(0, 127),
                   $urandom_range(0, 127));
    if (r < 55)
      return mk_in(OP_NOTE_ON, rand_chan(), pick_note(), $urandom_range(1, 127));
    r = $urandom_range(0, 99);
    if (cur_on && r < 50) n = cur_note;
    else n = pick_note();
    if ($urandom_range(0, 99) < 15) return mk_in(OP_NOTE_ON, rand_chan(), n, 0);
    return mk_in(OP_NOTE_OFF, rand_chan(), n, $urandom_range(0, 127));
  endfunction

  initial begin
    int sent;
    int burst;
    int burst_len;
    voice_clear_all();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 1, 60, 0), 1, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 1, 0, 127), 1, 1, mk_out(1, 1, 0, 127, 0)));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 16, 127, 1), 1, 1, mk_out(1, 16, 127, 1, 0)));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 16, 127, 55), 1, 1, mk_out(1, 16, 0, 1, 0)));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 3, 0, 0), 1, 1, mk_out(0, 3, 0, 0, 0)));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 31, 5, 127), 1, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 0, 64, 100), 1, 1, mk_out(1, 0, 64, 100, 0)));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 2, 64, 20), 1, 1, mk_out(1, 2, 64, 20, 0)));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 2, 70, 90), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 4, 72, 80), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 4, 70, 33), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 5, 70, 10), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 17, 72, 0), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 8, 70, 64), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 9, 64, 1), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 9, 64, 1), 0, 0, '0));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_ON, 31, 127, 127), 1, 1,
                             mk_out(1, 31, 127, 127, 0)));
    dir_tab.push_back(mk_row(mk_in(OP_NOTE_OFF, 31, 127, 127), 1, 1,
                             mk_out(0, 31, 127, 0, 0)));

    foreach (dir_tab[k]) offer(dir_tab[k].ev, dir_tab[k].typed, dir_tab[k].want, dir_tab[k].res);
    fill_stack();

    sent  = 0;
    burst = 0;
    while (sent < RAND_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      foreach (pool[k]) pool[k] = NOTE_W'($urandom_range(0, 127));
      if (burst == 5 || burst == 12) begin
        fill_stack();
        sent += 2 * NOTE_COUNT + 7;
      end else begin
        burst_len = $urandom_range(20, 80);
        for (int k = 0; k < burst_len; k++) offer(rand_event(), 0, 0, '0);
        sent += burst_len;
      end
      burst++;
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_voice.size() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    if (pending_voice.size() != 0)
      flag_mismatch($sformatf("%0d beats never arrived", pending_voice.size()));

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/lnpv_pkg.sv
sv/lnpv_ram.sv
sv/last_note_priority_voice.sv
test/tb.sv
